>>> hw/rtl/sorted_set_table_assert.svh
// assertion macros used by sorted_set_table.sv
// both sample on clk and are disabled while arst_n is low
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// same-cycle implication
`define SST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted set table check failed");

// next-cycle implication
`define SST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted set table check failed");

`endif

>>> hw/rtl/sst_pkg.sv
package sst_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam int DEF_CAPACITY = 64;

	// port widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 7;
	localparam int OUT_DATA_W = 16;

	// controller to datapath commands
	typedef struct packed {
		logic start;
		logic read;
		logic eval;
		logic tail;
		logic emit;
	} sst_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic at_end;
		logic stop;
		logic out_free;
	} sst_stat_t;

endpackage

>>> hw/rtl/sst_ctrl.sv
module sst_ctrl
	import sst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  sst_stat_t stat,
	output sst_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and command decode
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.at_end) begin
					cmd.tail = 1'b1;
					state_d  = ST_FIN;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				cmd.eval = 1'b1;
				state_d  = stat.stop ? ST_FIN : ST_CHK;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/sst_dpath.sv
module sst_dpath
	import sst_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sst_cmd_t              cmd,
	output sst_stat_t             stat,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PAD_W = OUT_DATA_W - COUNT_W - 2;

	// entry store, never cleared: only entries below the count are read
	logic signed [VALUE_W-1:0] mem [CAPACITY];

	logic [1:0]                op_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             count_q;
	logic signed [VALUE_W-1:0] carry_q;
	logic signed [VALUE_W-1:0] rd_data_q;
	logic                      found_q;
	logic                      hit_q;
	logic                      rej_q;
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	logic [CW-1:0]             idx_m1;
	logic                      e_lt;
	logic                      e_eq;
	logic                      is_ins;
	logic                      is_del;
	logic                      full;
	logic                      we;
	logic [AW-1:0]             waddr;
	logic signed [VALUE_W-1:0] wdata;

	// compare of the fetched entry against the request value
	assign idx_m1 = idx_q - CW'(1);
	assign e_lt   = rd_data_q < val_q;
	assign e_eq   = rd_data_q == val_q;
	assign is_ins = op_q == OP_INSERT;
	assign is_del = op_q == OP_DELETE;
	assign full   = count_q == CW'(CAPACITY);

	// status back to the controller
	assign stat.at_end   = idx_q == count_q;
	assign stat.stop     = !found_q && !e_lt && (e_eq ? !is_del : (!is_ins || full));
	assign stat.out_free = !m_tvalid_q || m_tready;

	// store write select
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = val_q;
		if (cmd.tail && is_ins) begin
			if (found_q) begin
				we    = 1'b1;
				wdata = carry_q;
			end else if (!full) begin
				we = 1'b1;
			end
		end else if (cmd.eval) begin
			if (!found_q) begin
				// new value goes in front of the first larger entry
				we = !e_lt && !e_eq && is_ins && !full;
			end else if (is_ins) begin
				we    = 1'b1;
				wdata = carry_q;
			end else if (is_del) begin
				we    = 1'b1;
				waddr = idx_m1[AW-1:0];
				wdata = rd_data_q;
			end
		end
	end

	// single port store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.read) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	// request payload and shift carry
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= s_tuser;
			val_q <= s_tdata[VALUE_W-1:0];
		end
		if (cmd.eval) begin
			carry_q <= rd_data_q;
		end
	end

	// scan index, flags and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			rej_q   <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			rej_q   <= 1'b0;
		end else if (cmd.eval) begin
			if (found_q) begin
				idx_q <= idx_q + CW'(1);
			end else if (e_lt) begin
				idx_q <= idx_q + CW'(1);
			end else if (e_eq) begin
				hit_q <= 1'b1;
				if (is_del) begin
					found_q <= 1'b1;
					idx_q   <= idx_q + CW'(1);
				end
			end else if (is_ins) begin
				if (full) begin
					rej_q <= 1'b1;
				end else begin
					found_q <= 1'b1;
					idx_q   <= idx_q + CW'(1);
				end
			end
		end else if (cmd.tail) begin
			if (is_ins) begin
				if (found_q || !full) begin
					count_q <= count_q + CW'(1);
				end else begin
					rej_q <= 1'b1;
				end
			end else if (is_del && found_q) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= {PAD_W'(0), rej_q, COUNT_W'(count_q), hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/sorted_set_table.sv
// channel  dir  tdata                                  tuser
// s        in   [31:0] value                           [1:0] op
// m        out  [0] was_present [7:1] count            -
//               [8] rejected_full [15:9] zero
//
// per request: each entry visited passes through a check state and a read state
// (single-port store, registered read, entries shifted on the way) until the scan
// stops on an entry or runs to the end; then the result waits for the output
// reset clears the count and control state; the store needs no clearing pass
// the next request is accepted while a result still waits on m
// a finished request holds in the controller until the result register frees
`include "sorted_set_table_assert.svh"

module sorted_set_table
	import sst_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic [IN_USER_W-1:0]  s_tuser,  // [1:0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [0] was_present, [7:1] count, [8] rejected_full
);

	sst_cmd_t  cmd;
	sst_stat_t stat;

	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sst_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a refused insert only happens with the store full and the value absent
	`SST_ASSERT_IMP(a_rej_count, m_tvalid && m_tdata[8], m_tdata[7:1] == COUNT_W'(CAPACITY))
	`SST_ASSERT_IMP(a_rej_absent, m_tvalid && m_tdata[8], !m_tdata[0])
	// the controller goes busy right after taking a request
	`SST_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

endmodule
